/* rtl/core/ata_tf_pkg.sv */
`timescale 1ns / 1ps
package ata_tf_pkg;

    // APB address width: eight 32-bit registers
    localparam int AddrW = 5;

    // register indexes (paddr[4:2])
    localparam logic [2:0] RegPriCmd  = 3'd0;
    localparam logic [2:0] RegPriCtl  = 3'd1;
    localparam logic [2:0] RegSecCmd  = 3'd2;
    localparam logic [2:0] RegSecCtl  = 3'd3;
    localparam logic [2:0] RegPriMask = 3'd4;
    localparam logic [2:0] RegSecMask = 3'd5;
    localparam logic [2:0] RegLba48   = 3'd6;
    localparam logic [2:0] RegLba28   = 3'd7;

    // register reset values
    localparam logic [15:0] RstPriCmd = 16'h01F0;
    localparam logic [15:0] RstPriCtl = 16'h03F4;
    localparam logic [15:0] RstSecCmd = 16'h0170;
    localparam logic [15:0] RstSecCtl = 16'h0374;

    // taskfile register offsets from the command block base
    localparam logic [15:0] OffCount = 16'd2;
    localparam logic [15:0] OffLba0  = 16'd3;
    localparam logic [15:0] OffLba1  = 16'd4;
    localparam logic [15:0] OffLba2  = 16'd5;
    localparam logic [15:0] OffSel   = 16'd6;
    localparam logic [15:0] OffCmd   = 16'd7;
    // device control register offset from the control block base
    localparam logic [15:0] OffCtl   = 16'd2;

    // byte values
    localparam logic [7:0] DevSelChs  = 8'hA0;
    localparam logic [7:0] DevSelLba  = 8'hE0;
    localparam logic [7:0] CtlHob     = 8'h80;
    localparam logic [7:0] OpRead     = 8'h20;
    localparam logic [7:0] OpReadExt  = 8'h24;
    localparam logic [7:0] OpWrite    = 8'h30;
    localparam logic [7:0] OpWriteExt = 8'h34;

    // CHS geometry: 63 sectors per track
    localparam logic [6:0]  SecPerTrack = 7'd63;
    // inverse of 63 modulo 2^20, for exact division of lba - rem
    localparam logic [19:0] Inv63       = 20'd782271;

    typedef enum logic [1:0] {
        MODE_CHS   = 2'd0,
        MODE_LBA28 = 2'd1,
        MODE_LBA48 = 2'd2
    } t_mode;

    // write run; LBA28/CHS skip the high-order block
    typedef enum logic [4:0] {
        ST_SEL    = 5'd0,
        ST_H0_ON  = 5'd1,
        ST_H0_WR  = 5'd2,
        ST_H0_OFF = 5'd3,
        ST_H1_ON  = 5'd4,
        ST_H1_WR  = 5'd5,
        ST_H1_OFF = 5'd6,
        ST_H2_ON  = 5'd7,
        ST_H2_WR  = 5'd8,
        ST_H2_OFF = 5'd9,
        ST_H3_ON  = 5'd10,
        ST_H3_WR  = 5'd11,
        ST_H3_OFF = 5'd12,
        ST_COUNT  = 5'd13,
        ST_LBA0   = 5'd14,
        ST_LBA1   = 5'd15,
        ST_LBA2   = 5'd16,
        ST_CMD    = 5'd17
    } t_step;

    // one request as it moves down the address pipeline
    typedef struct packed {
        logic        ch;
        logic        sl;
        logic [31:0] lba;
        logic [7:0]  count;
        logic        wr;
        t_mode       mode;
        logic [8:0]  dsum;   // sum of 6-bit digits of the 48-bit lba
        logic [5:0]  rem;    // lba mod 63
        logic [19:0] track;  // lba - rem in stage 2, low track bits after stage 3
    } t_item;

endpackage

/* rtl/core/ata_tf_addr.sv */
`timescale 1ns / 1ps
module ata_tf_addr (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_channel,
    input  logic                i_slave,
    input  logic [47:0]         i_block_address,
    input  logic [7:0]          i_sector_count,
    input  logic                i_is_write,
    input  logic [3:0]          i_lba48_drives,
    input  logic [3:0]          i_lba28_drives,
    output logic                o_valid,
    input  logic                i_stall,
    output ata_tf_pkg::t_item   o_item
);

    logic              r_v1, r_v2, r_v3;
    ata_tf_pkg::t_item r_s1, r_s2, r_s3;
    ata_tf_pkg::t_item n_s1, n_s2, n_s3;
    logic              s1_rdy, s2_rdy, s3_rdy;
    logic [1:0]        drive;
    logic [8:0]        dsum;
    logic [6:0]        fold;
    logic [5:0]        rem;
    logic [19:0]       prod;

    // stage readiness, back from the consumer
    assign s3_rdy  = !r_v3 || !i_stall;
    assign s2_rdy  = !r_v2 || s3_rdy;
    assign s1_rdy  = !r_v1 || s2_rdy;
    assign o_stall = !s1_rdy;

    // stage 1: mode decode, digit sum (64 = 1 mod 63)
    always_comb begin
        drive = {i_channel, i_slave};
        dsum  = '0;
        for (int k = 0; k < 8; k++) begin
            dsum = dsum + 9'(i_block_address[6*k +: 6]);
        end
        n_s1       = '0;
        n_s1.ch    = i_channel;
        n_s1.sl    = i_slave;
        n_s1.lba   = i_block_address[31:0];
        n_s1.count = i_sector_count;
        n_s1.wr    = i_is_write;
        n_s1.dsum  = dsum;
        if (i_lba48_drives[drive]) begin
            n_s1.mode = ata_tf_pkg::MODE_LBA48;
        end else if (i_lba28_drives[drive]) begin
            n_s1.mode = ata_tf_pkg::MODE_LBA28;
        end else begin
            n_s1.mode = ata_tf_pkg::MODE_CHS;
        end
    end

    // stage 2: fold digit sum to remainder, form lba - rem
    always_comb begin
        fold = 7'(r_s1.dsum[5:0]) + 7'(r_s1.dsum[8:6]);
        if (fold >= ata_tf_pkg::SecPerTrack) begin
            rem = 6'(fold - ata_tf_pkg::SecPerTrack);
        end else begin
            rem = fold[5:0];
        end
        n_s2       = r_s1;
        n_s2.rem   = rem;
        n_s2.track = r_s1.lba[19:0] - 20'(rem);
    end

    // stage 3: exact divide by 63, low 20 bits are enough
    always_comb begin
        prod       = r_s2.track * ata_tf_pkg::Inv63;
        n_s3       = r_s2;
        n_s3.track = prod;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s1_rdy) r_v1 <= i_valid;
            if (s2_rdy) r_v2 <= r_v1;
            if (s3_rdy) r_v3 <= r_v2;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_valid) r_s1 <= n_s1;
        if (s2_rdy && r_v1)    r_s2 <= n_s2;
        if (s3_rdy && r_v2)    r_s3 <= n_s3;
    end

    assign o_valid = r_v3;
    assign o_item  = r_s3;

endmodule

/* rtl/core/ata_taskfile_command_issue_unit.sv */
`timescale 1ns / 1ps
// First port write of an item is registered in r_s1, r_s2, r_s3, r_e and then the output register.
// Throughput: one port write per cycle while i_stall is low; an item takes 18 writes in LBA48 mode and
// 6 writes in LBA28/CHS mode, set by the write sequencer issuing one write a cycle.
// The three-stage address pipeline (mod 63, exact divide) overlaps the previous run.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
module ata_taskfile_command_issue_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_channel,
    input  logic                         i_slave,
    input  logic [47:0]                  i_block_address,
    input  logic [7:0]                   i_sector_count,
    input  logic                         i_is_write,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [15:0]                  o_port_address,
    output logic [7:0]                   o_port_value,
    output logic                         o_last_write,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ata_tf_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [15:0]       r_pri_cmd, r_pri_ctl, r_sec_cmd, r_sec_ctl;
    logic [7:0]        r_pri_mask, r_sec_mask;
    logic [3:0]        r_lba48, r_lba28;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    logic              addr_valid;
    ata_tf_pkg::t_item addr_item;

    logic              r_e_valid;
    ata_tf_pkg::t_item r_e;
    ata_tf_pkg::t_step r_step, n_step;
    logic              e_rdy, e_fire, e_load, out_rdy;

    logic              r_o_valid, r_o_last;
    logic [15:0]       r_o_port;
    logic [7:0]        r_o_value;
    logic [15:0]       n_port;
    logic [7:0]        n_value;
    logic              n_last;

    logic [15:0]       cmd_base, ctl_port;
    logic [7:0]        mask, sel, a0, a1, a2, a3, opcode;
    logic [3:0]        head;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ata_tf_pkg::AddrW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri_cmd  <= ata_tf_pkg::RstPriCmd;
            r_pri_ctl  <= ata_tf_pkg::RstPriCtl;
            r_sec_cmd  <= ata_tf_pkg::RstSecCmd;
            r_sec_ctl  <= ata_tf_pkg::RstSecCtl;
            r_pri_mask <= '0;
            r_sec_mask <= '0;
            r_lba48    <= '0;
            r_lba28    <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                ata_tf_pkg::RegPriCmd:  r_pri_cmd  <= pwdata[15:0];
                ata_tf_pkg::RegPriCtl:  r_pri_ctl  <= pwdata[15:0];
                ata_tf_pkg::RegSecCmd:  r_sec_cmd  <= pwdata[15:0];
                ata_tf_pkg::RegSecCtl:  r_sec_ctl  <= pwdata[15:0];
                ata_tf_pkg::RegPriMask: r_pri_mask <= pwdata[7:0];
                ata_tf_pkg::RegSecMask: r_sec_mask <= pwdata[7:0];
                ata_tf_pkg::RegLba48:   r_lba48    <= pwdata[3:0];
                ata_tf_pkg::RegLba28:   r_lba28    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (cfg_idx)
            ata_tf_pkg::RegPriCmd:  prdata = 32'(r_pri_cmd);
            ata_tf_pkg::RegPriCtl:  prdata = 32'(r_pri_ctl);
            ata_tf_pkg::RegSecCmd:  prdata = 32'(r_sec_cmd);
            ata_tf_pkg::RegSecCtl:  prdata = 32'(r_sec_ctl);
            ata_tf_pkg::RegPriMask: prdata = 32'(r_pri_mask);
            ata_tf_pkg::RegSecMask: prdata = 32'(r_sec_mask);
            ata_tf_pkg::RegLba48:   prdata = 32'(r_lba48);
            ata_tf_pkg::RegLba28:   prdata = 32'(r_lba28);
            default:                prdata = '0;
        endcase
    end

    // address pipeline: mode, lba mod 63, track
    ata_tf_addr u_addr (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_channel       (i_channel),
        .i_slave         (i_slave),
        .i_block_address (i_block_address),
        .i_sector_count  (i_sector_count),
        .i_is_write      (i_is_write),
        .i_lba48_drives  (r_lba48),
        .i_lba28_drives  (r_lba28),
        .o_valid         (addr_valid),
        .i_stall         (!e_rdy),
        .o_item          (addr_item)
    );

    // sequencer handshake
    assign out_rdy = !r_o_valid || !i_stall;
    assign e_fire  = r_e_valid && out_rdy;
    assign e_rdy   = !r_e_valid || (out_rdy && (r_step == ata_tf_pkg::ST_CMD));
    assign e_load  = addr_valid && e_rdy;

    // next step; non-LBA48 runs skip the high-order block
    always_comb begin
        if (r_step == ata_tf_pkg::ST_SEL && r_e.mode != ata_tf_pkg::MODE_LBA48) begin
            n_step = ata_tf_pkg::ST_COUNT;
        end else begin
            n_step = ata_tf_pkg::t_step'(r_step + 5'd1);
        end
    end

    // per-item byte values
    always_comb begin
        cmd_base = r_e.ch ? r_sec_cmd : r_pri_cmd;
        ctl_port = (r_e.ch ? r_sec_ctl : r_pri_ctl) + ata_tf_pkg::OffCtl;
        mask     = r_e.ch ? r_sec_mask : r_pri_mask;
        a3       = r_e.lba[31:24];
        case (r_e.mode)
            ata_tf_pkg::MODE_LBA48: begin
                a0     = r_e.lba[7:0];
                a1     = r_e.lba[15:8];
                a2     = r_e.lba[23:16];
                head   = 4'd0;
                sel    = ata_tf_pkg::DevSelLba;
                opcode = r_e.wr ? ata_tf_pkg::OpWriteExt : ata_tf_pkg::OpReadExt;
            end
            ata_tf_pkg::MODE_LBA28: begin
                a0     = r_e.lba[7:0];
                a1     = r_e.lba[15:8];
                a2     = r_e.lba[23:16];
                head   = r_e.lba[27:24];
                sel    = ata_tf_pkg::DevSelLba;
                opcode = r_e.wr ? ata_tf_pkg::OpWrite : ata_tf_pkg::OpRead;
            end
            default: begin
                // CHS: sector = rem + 1, cylinder = track / 16, head = track % 16
                a0     = 8'(r_e.rem) + 8'd1;
                a1     = r_e.track[11:4];
                a2     = r_e.track[19:12];
                head   = r_e.track[3:0];
                sel    = ata_tf_pkg::DevSelChs;
                opcode = r_e.wr ? ata_tf_pkg::OpWrite : ata_tf_pkg::OpRead;
            end
        endcase
        sel = sel | {3'd0, r_e.sl, head};
    end

    // port write for the current step
    always_comb begin
        n_last = (r_step == ata_tf_pkg::ST_CMD);
        case (r_step)
            ata_tf_pkg::ST_SEL: begin
                n_port = cmd_base + ata_tf_pkg::OffSel;   n_value = sel;
            end
            ata_tf_pkg::ST_H0_ON, ata_tf_pkg::ST_H1_ON,
            ata_tf_pkg::ST_H2_ON, ata_tf_pkg::ST_H3_ON: begin
                n_port = ctl_port;                        n_value = ata_tf_pkg::CtlHob | mask;
            end
            ata_tf_pkg::ST_H0_OFF, ata_tf_pkg::ST_H1_OFF,
            ata_tf_pkg::ST_H2_OFF, ata_tf_pkg::ST_H3_OFF: begin
                n_port = ctl_port;                        n_value = mask;
            end
            ata_tf_pkg::ST_H0_WR: begin
                n_port = cmd_base + ata_tf_pkg::OffCount; n_value = 8'd0;
            end
            ata_tf_pkg::ST_H1_WR: begin
                n_port = cmd_base + ata_tf_pkg::OffLba0;  n_value = a3;
            end
            ata_tf_pkg::ST_H2_WR: begin
                n_port = cmd_base + ata_tf_pkg::OffLba1;  n_value = 8'd0;
            end
            ata_tf_pkg::ST_H3_WR: begin
                n_port = cmd_base + ata_tf_pkg::OffLba2;  n_value = 8'd0;
            end
            ata_tf_pkg::ST_COUNT: begin
                n_port = cmd_base + ata_tf_pkg::OffCount; n_value = r_e.count;
            end
            ata_tf_pkg::ST_LBA0: begin
                n_port = cmd_base + ata_tf_pkg::OffLba0;  n_value = a0;
            end
            ata_tf_pkg::ST_LBA1: begin
                n_port = cmd_base + ata_tf_pkg::OffLba1;  n_value = a1;
            end
            ata_tf_pkg::ST_LBA2: begin
                n_port = cmd_base + ata_tf_pkg::OffLba2;  n_value = a2;
            end
            ata_tf_pkg::ST_CMD: begin
                n_port = cmd_base + ata_tf_pkg::OffCmd;   n_value = opcode;
            end
            default: begin
                n_port = cmd_base;                        n_value = 8'd0;
            end
        endcase
    end

    // sequencer and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_step    <= ata_tf_pkg::ST_SEL;
            r_o_valid <= 1'b0;
        end else begin
            if (e_rdy) r_e_valid <= addr_valid;
            if (e_load) begin
                r_step <= ata_tf_pkg::ST_SEL;
            end else if (e_fire) begin
                r_step <= n_step;
            end
            if (out_rdy) r_o_valid <= r_e_valid;
        end
    end

    // sequencer and output payload
    always_ff @(posedge i_clk) begin
        if (e_load) r_e <= addr_item;
        if (e_fire) begin
            r_o_port  <= n_port;
            r_o_value <= n_value;
            r_o_last  <= n_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_port_address = r_o_port;
    assign o_port_value   = r_o_value;
    assign o_last_write   = r_o_last;

    // LBA28/CHS runs never visit the high-order block
    a_skip_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && r_e.mode != ata_tf_pkg::MODE_LBA48) |->
        (r_step == ata_tf_pkg::ST_SEL || r_step >= ata_tf_pkg::ST_COUNT))
        else $error("high-order step in non-LBA48 run");

    // remainder stays below 63
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> (r_e.rem < 6'd63))
        else $error("sector remainder out of range");

    // issuing the opcode step marks the output as last
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_fire && r_step == ata_tf_pkg::ST_CMD) |=> (r_o_valid && r_o_last))
        else $error("opcode write not marked last");

    // last write always carries an opcode
    a_last_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |->
        (r_o_value == ata_tf_pkg::OpRead || r_o_value == ata_tf_pkg::OpWrite ||
         r_o_value == ata_tf_pkg::OpReadExt || r_o_value == ata_tf_pkg::OpWriteExt))
        else $error("last write is not an opcode");

endmodule
